[hw/rtl/lbm_pkg.sv]
// lbm_pkg: payload types and fixed-point constants of the lorentz boost block
// no dependencies
`timescale 1ns / 1ps

package lbm_pkg;

    localparam int MOM_W     = 32;
    localparam int BETA_W    = 32;
    localparam int GAM_STEPS = 63;
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;
    localparam int N_STEPS   = GAM_STEPS + DIV_STEPS;

    localparam logic [187:0] GAM_LIMIT = 188'(1) << 126;
    localparam logic [65:0]  BETA_ONE  = 66'(1) << 60;
    localparam logic [64:0]  DIV_NUM   = 65'(1) << 64;
    localparam logic [63:0]  G_ONE     = 64'(1) << 32;

    typedef struct packed {
        logic        [MOM_W-2:0]  rest_mass;
        logic signed [MOM_W-1:0]  mom_x;
        logic signed [MOM_W-1:0]  mom_y;
        logic signed [MOM_W-1:0]  mom_z;
        logic signed [BETA_W-1:0] beta_x;
        logic signed [BETA_W-1:0] beta_y;
        logic signed [BETA_W-1:0] beta_z;
    } t_in_item;

    typedef struct packed {
        logic signed [MOM_W-1:0] boosted_x;
        logic signed [MOM_W-1:0] boosted_y;
        logic signed [MOM_W-1:0] boosted_z;
        logic                    invalid;
        logic                    saturated;
    } t_out_item;

endpackage

[hw/rtl/lbm_stream_if.sv]
// lbm_stream_if: valid/ready channel carrying one payload item per transfer
// payload type is set by the instantiating level
`timescale 1ns / 1ps

interface lbm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/lorentz_boost_momentum_top.sv]
// Lorentz boost of a particle momentum in a boost frame, Q16.16 momenta, Q2.30 beta.
// Uses lbm_pkg and lbm_stream_if.
// One item is taken per cycle while the output is not stalled and passes through 106 register
// stages before its result is ready for transfer. The stages are made up of the bit-serial search
// for gamma (63 stages, one bit each, the energy square root running alongside in the first
// 32) and the 32-stage division that forms gamma^2/(gamma+1), plus three input stages and
// eight multiply and saturate stages. The whole pipeline holds when the output transfer is
// stalled; if beta squared is at least one the result is flagged invalid with zero momentum.
`timescale 1ns / 1ps

module lorentz_boost_momentum_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lbm_stream_if.sink   i_in,
    lbm_stream_if.source o_out
);
    import lbm_pkg::*;

    typedef struct packed {
        logic                inv;
        logic [2:0][31:0]    p;
        logic [2:0][31:0]    nb;
        logic signed [34:0]  bp;
        logic [62:0]         u;
        logic [127:0]        ga;
        logic [127:0]        gb;
        logic [62:0]         gt;
        logic [63:0]         erem;
        logic [31:0]         er;
        logic [64:0]         drem;
        logic [31:0]         dq;
    } t_pipe;

    function automatic t_pipe f_gam(t_pipe x, int b);
        logic [187:0] ta;
        ta = {60'b0, x.ga} + ({60'b0, x.gb} << (b + 1)) + ({125'b0, x.u} << (2 * b));
        if (ta <= GAM_LIMIT) begin
            x.ga    = ta[127:0];
            x.gb    = x.gb + ({65'b0, x.u} << b);
            x.gt[b] = 1'b1;
        end
        return x;
    endfunction

    function automatic t_pipe f_sqrt(t_pipe x, int b);
        logic [65:0] tr;
        tr = ({34'b0, x.er} << (b + 1)) + (66'd1 << (2 * b));
        if ({2'b0, x.erem} >= tr) begin
            x.erem  = 64'({2'b0, x.erem} - tr);
            x.er[b] = 1'b1;
        end
        return x;
    endfunction

    function automatic t_pipe f_div(t_pipe x, int b);
        logic [63:0] d;
        logic [95:0] tr;
        d  = {1'b0, x.gt} + G_ONE;
        tr = {32'b0, d} << b;
        if ({31'b0, x.drem} >= tr) begin
            x.drem  = x.drem - tr[64:0];
            x.dq[b] = 1'b1;
        end
        return x;
    endfunction

    logic en;

    // input stage
    logic     r_v0;
    t_in_item r_d0;

    // products
    logic                    r_v1;
    logic [2:0][31:0]        r1_p;
    logic [2:0][31:0]        r1_nb;
    logic [2:0][63:0]        r1_sqb;
    logic [2:0][63:0]        r1_sqp;
    logic [61:0]             r1_sqm;
    logic signed [63:0]      r1_pr [3];

    // iterative stages
    logic  [N_STEPS:0] r_pv;
    t_pipe             r_ps [N_STEPS+1];
    t_pipe             n_ps [N_STEPS];

    // late stages
    logic [8:1]              r_lv;
    logic [7:1]              r_linv;
    logic [2:0][31:0]        r_lp [6:1];
    logic [2:0][31:0]        r_lnb [4:1];
    logic signed [34:0]      r1l_bp;
    logic [62:0]             r1l_h;
    logic [63:0]             r1l_pglo;
    logic [62:0]             r1l_pghi;
    logic [94:0]             r2l_ge;
    logic [94:0]             r3l_ge;
    logic signed [67:0]      r2l_phlo;
    logic signed [66:0]      r2l_phhi;
    logic signed [99:0]      r3l_hb;
    logic signed [65:0]      r4l_k;
    logic signed [64:0]      r5l_plo [3];
    logic signed [65:0]      r5l_phi [3];
    logic signed [99:0]      r6l_pr [3];
    logic signed [67:0]      r7l_v [3];
    t_out_item               r_out;

    logic [65:0]        n_b2;
    logic [65:0]        n_esq;
    logic signed [65:0] n_bps;
    t_pipe              n_p0;

    assign en          = !r_lv[8] || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_lv[8];
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_pv <= '0;
            r_lv <= '0;
        end else if (en) begin
            r_v0 <= i_in.valid;
            r_v1 <= r_v0;
            r_pv <= {r_pv[N_STEPS-1:0], r_v1};
            r_lv <= {r_lv[7:1], r_pv[N_STEPS]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d0 <= i_in.data;
        end
    end

    // squares and beta-momentum products
    always_ff @(posedge i_clk) begin
        logic signed [31:0] bt [3];
        logic signed [31:0] pt [3];
        logic        [31:0] bm;
        logic        [31:0] pm;
        logic signed [31:0] nbt;
        if (en) begin
            bt[0] = r_d0.beta_x;
            bt[1] = r_d0.beta_y;
            bt[2] = r_d0.beta_z;
            pt[0] = r_d0.mom_x;
            pt[1] = r_d0.mom_y;
            pt[2] = r_d0.mom_z;
            for (int i = 0; i < 3; i++) begin
                bm  = bt[i][31] ? 32'(-bt[i]) : bt[i];
                pm  = pt[i][31] ? 32'(-pt[i]) : pt[i];
                nbt = bt[i] <<< 1;
                r1_sqb[i] <= bm * bm;
                r1_sqp[i] <= pm * pm;
                r1_pr[i]  <= nbt * pt[i];
                r1_p[i]   <= pt[i];
                r1_nb[i]  <= nbt;
            end
            r1_sqm <= r_d0.rest_mass * r_d0.rest_mass;
        end
    end

    // sums and search start values
    always_comb begin
        n_b2  = 66'(r1_sqb[0]) + 66'(r1_sqb[1]) + 66'(r1_sqb[2]);
        n_esq = 66'(r1_sqm) + 66'(r1_sqp[0]) + 66'(r1_sqp[1]) + 66'(r1_sqp[2]);
        n_bps = 66'(r1_pr[0]) + 66'(r1_pr[1]) + 66'(r1_pr[2]);
        n_p0      = '0;
        n_p0.inv  = n_b2 >= BETA_ONE;
        n_p0.p    = r1_p;
        n_p0.nb   = r1_nb;
        n_p0.bp   = n_bps[65:31];
        n_p0.u    = 63'((66'(1) << 62) - (n_b2 << 2));
        n_p0.erem = n_esq[63:0];
        n_p0.drem = DIV_NUM;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ps[0] <= n_p0;
        end
    end

    for (genvar j = 0; j < N_STEPS; j++) begin : g_st
        if (j < SQ_STEPS) begin : g_gs
            always_comb n_ps[j] = f_sqrt(f_gam(r_ps[j], GAM_STEPS - 1 - j), SQ_STEPS - 1 - j);
        end else if (j < GAM_STEPS) begin : g_g
            always_comb n_ps[j] = f_gam(r_ps[j], GAM_STEPS - 1 - j);
        end else begin : g_d
            always_comb n_ps[j] = f_div(r_ps[j], N_STEPS - 1 - j);
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ps[j+1] <= n_ps[j];
            end
        end
    end

    // gamma^2/(gamma+1), gamma times energy, boost factor, boosted components
    always_ff @(posedge i_clk) begin
        logic [62:0] g;
        logic [31:0] e;
        logic [33:0] khi;
        logic [67:0] lim;
        logic [31:0] o;
        logic        sat;
        if (en) begin
            g = r_ps[N_STEPS].gt;
            e = r_ps[N_STEPS].er;
            r1l_h    <= 63'({1'b0, g} - G_ONE + {32'b0, r_ps[N_STEPS].dq});
            r1l_pglo <= g[31:0] * e;
            r1l_pghi <= g[62:32] * e;
            r_linv[1] <= r_ps[N_STEPS].inv;
            r_lp[1]   <= r_ps[N_STEPS].p;
            r_lnb[1]  <= r_ps[N_STEPS].nb;
            r1l_bp    <= r_ps[N_STEPS].bp;

            r2l_ge   <= {r1l_pghi, 32'b0} + {31'b0, r1l_pglo};
            r2l_phlo <= $signed({1'b0, r1l_h[31:0]}) * r1l_bp;
            r2l_phhi <= $signed({1'b0, r1l_h[62:32]}) * r1l_bp;

            r3l_hb <= (100'(r2l_phhi) <<< 32) + 100'(r2l_phlo);
            r3l_ge <= r2l_ge;

            r4l_k <= $signed(r3l_hb[97:32]) + $signed({3'b0, r3l_ge[94:32]});

            khi = r4l_k[65:32];
            for (int i = 0; i < 3; i++) begin
                r5l_plo[i] <= $signed({1'b0, r4l_k[31:0]}) * $signed(r_lnb[4][i]);
                r5l_phi[i] <= $signed(khi) * $signed(r_lnb[4][i]);
                r6l_pr[i]  <= (100'(r5l_phi[i]) <<< 32) + 100'(r5l_plo[i]);
                r7l_v[i]   <= 68'($signed(r_lp[6][i])) + $signed(r6l_pr[i][98:31]);
            end

            for (int s = 2; s <= 7; s++) begin
                r_linv[s] <= r_linv[s-1];
            end
            for (int s = 2; s <= 6; s++) begin
                r_lp[s] <= r_lp[s-1];
            end
            for (int s = 2; s <= 4; s++) begin
                r_lnb[s] <= r_lnb[s-1];
            end

            sat = 1'b0;
            r_out.invalid <= r_linv[7];
            for (int i = 0; i < 3; i++) begin
                lim = r7l_v[i];
                if (lim[67:31] == '0 || lim[67:31] == '1) begin
                    o = lim[31:0];
                end else begin
                    o = lim[67] ? 32'h8000_0000 : 32'h7fff_ffff;
                    if (!r_linv[7]) begin
                        sat = 1'b1;
                    end
                end
                if (r_linv[7]) begin
                    o = '0;
                end
                unique case (i)
                    0:       r_out.boosted_x <= o;
                    1:       r_out.boosted_y <= o;
                    default: r_out.boosted_z <= o;
                endcase
            end
            r_out.saturated <= sat;
        end
    end

endmodule
